// ===== sv/websocket_frame_deframer_core_defines.svh =====
// Assertion macros shared by the deframer RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge out of reset
`define WSFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, checked at every rising edge out of reset
`define WSFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

// ===== sv/wsfd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// No dependencies; used by wsfd_parser and websocket_frame_deframer_core.
package wsfd_pkg;

    // Parser phase, one-hot
    typedef enum logic [4:0] {
        PH_HDR0 = 5'b00001,
        PH_HDR1 = 5'b00010,
        PH_EXT  = 5'b00100,
        PH_KEY  = 5'b01000,
        PH_DATA = 5'b10000
    } phase_t;

    // Header field constants
    localparam int unsigned FIN_BIT      = 7;
    localparam int unsigned MASK_BIT     = 7;
    localparam logic [6:0]  LEN7_EXT16   = 7'd126;
    localparam logic [6:0]  LEN7_EXT64   = 7'd127;
    localparam logic [3:0]  OPC_TEXT     = 4'h1;
    localparam logic [3:0]  EXT16_BYTES  = 4'd2;
    localparam logic [3:0]  EXT64_BYTES  = 4'd8;
    localparam logic [3:0]  KEY_BYTES    = 4'd4;

    // One result from the parser toward the output stage
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       last;
        logic       fin;
    } result_t;

endpackage

// ===== sv/websocket_frame_deframer_core.sv =====
// Channel   | Dir | Signals                        | Content
// s_axis    | in  | tvalid tready tdata[7:0]       | received framed byte stream
// m_axis    | out | tvalid tready tdata tlast tuser| unmasked text payload bytes
//
// One byte per cycle in while tready is high, zero or one result per byte out.
// Header parse, length count and unmask run in wsfd_parser as a single update
// per byte; a result register plus one skid entry decouple the output.
// s_axis_tready drops only while the skid entry is occupied.
// Reset (rst_n low, asynchronous) returns the parser to the first header byte
// and empties both output entries.
// Depends on wsfd_pkg, wsfd_parser and websocket_frame_deframer_core_defines.svh.
`include "websocket_frame_deframer_core_defines.svh"

module websocket_frame_deframer_core #(
    parameter int LENGTH_BITS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] in_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_byte
    output logic       m_axis_tlast,    // frame_end
    output logic [0:0] m_axis_tuser     // [0] frame_fin
);

    wsfd_pkg::result_t res;
    logic              in_accept;
    logic              out_pop;

    logic              out_valid_reg, out_valid_next;
    logic [7:0]        out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;
    logic              out_fin_reg, out_fin_next;
    logic              skid_valid_reg, skid_valid_next;
    logic [7:0]        skid_data_reg, skid_data_next;
    logic              skid_last_reg, skid_last_next;
    logic              skid_fin_reg, skid_fin_next;

    assign s_axis_tready = !skid_valid_reg;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_pop       = out_valid_reg && m_axis_tready;

    wsfd_parser #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_accept),
        .in_byte  (s_axis_tdata),
        .res      (res)
    );

    // Output register with one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_last_next   = out_last_reg;
        out_fin_next    = out_fin_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_last_next  = skid_last_reg;
        skid_fin_next   = skid_fin_reg;
        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_data_next   = skid_data_reg;
                out_last_next   = skid_last_reg;
                out_fin_next    = skid_fin_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (res.valid)
        begin
            if (!out_valid_reg || out_pop)
            begin
                out_valid_next = 1'b1;
                out_data_next  = res.data;
                out_last_next  = res.last;
                out_fin_next   = res.fin;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res.data;
                skid_last_next  = res.last;
                skid_fin_next   = res.fin;
            end
        end
        else if (out_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload holds need no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        out_last_reg  <= out_last_next;
        out_fin_reg   <= out_fin_next;
        skid_data_reg <= skid_data_next;
        skid_last_reg <= skid_last_next;
        skid_fin_reg  <= skid_fin_next;
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tlast    = out_last_reg;
    assign m_axis_tuser[0] = out_fin_reg;

    // Checks
    `WSFD_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `WSFD_ASSERT_IMPL(a_no_result_when_full, clk, rst_n, res.valid, !skid_valid_reg)
    `WSFD_ASSERT_NEXT(a_skid_kept_on_stall, clk, rst_n,
                      skid_valid_reg && !m_axis_tready, skid_valid_reg)

endmodule

// ===== sv/wsfd_parser.sv =====
// Byte-wise WebSocket header parser and payload unmasker.
// Depends on wsfd_pkg (phase_t, result_t, header constants).
module wsfd_parser #(
    parameter int LENGTH_BITS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,   // byte accepted this cycle
    input  logic [7:0]         in_byte,
    output wsfd_pkg::result_t  res
);

    wsfd_pkg::phase_t        phase_reg, phase_next;
    logic [3:0]              cnt_reg, cnt_next;
    logic                    long_reg, long_next;
    logic [3:0]              opcode_reg, opcode_next;
    logic                    fin_reg, fin_next;
    logic                    masked_reg, masked_next;
    logic [LENGTH_BITS-1:0]  len_reg, len_next;     // remaining payload bytes
    logic                    ovf_reg, ovf_next;     // length overflowed LENGTH_BITS
    logic [31:0]             key_reg, key_next;
    logic [1:0]              kidx_reg, kidx_next;

    logic [6:0]              len7;
    logic [LENGTH_BITS-1:0]  len_shift;
    logic                    ovf_shift;
    logic [LENGTH_BITS-1:0]  len_final;
    logic [3:0]              cnt_inc;
    logic [7:0]              key_byte;

    assign len7      = in_byte[6:0];
    assign len_shift = {len_reg[LENGTH_BITS-9:0], in_byte};
    assign ovf_shift = ovf_reg | (|len_reg[LENGTH_BITS-1:LENGTH_BITS-8]);
    assign len_final = ovf_shift ? {LENGTH_BITS{1'b1}} : len_shift;
    assign cnt_inc   = cnt_reg + 4'd1;
    // first key byte received sits in bits 31..24
    assign key_byte  = key_reg[{~kidx_reg, 3'b000} +: 8];

    // Next-state logic for one accepted byte
    always_comb
    begin
        phase_next  = phase_reg;
        cnt_next    = cnt_reg;
        long_next   = long_reg;
        opcode_next = opcode_reg;
        fin_next    = fin_reg;
        masked_next = masked_reg;
        len_next    = len_reg;
        ovf_next    = ovf_reg;
        key_next    = key_reg;
        kidx_next   = kidx_reg;
        res         = '0;
        if (in_valid)
        begin
            case (phase_reg)
                wsfd_pkg::PH_HDR1:
                begin
                    masked_next = in_byte[wsfd_pkg::MASK_BIT];
                    key_next    = '0;
                    len_next    = '0;
                    ovf_next    = 1'b0;
                    cnt_next    = '0;
                    kidx_next   = '0;
                    if (len7 == wsfd_pkg::LEN7_EXT16)
                    begin
                        long_next  = 1'b0;
                        phase_next = wsfd_pkg::PH_EXT;
                    end
                    else if (len7 == wsfd_pkg::LEN7_EXT64)
                    begin
                        long_next  = 1'b1;
                        phase_next = wsfd_pkg::PH_EXT;
                    end
                    else
                    begin
                        len_next = {{(LENGTH_BITS-7){1'b0}}, len7};
                        if (in_byte[wsfd_pkg::MASK_BIT])
                            phase_next = wsfd_pkg::PH_KEY;
                        else if (len7 == 7'd0)
                            phase_next = wsfd_pkg::PH_HDR0;
                        else
                            phase_next = wsfd_pkg::PH_DATA;
                    end
                end
                wsfd_pkg::PH_EXT:
                begin
                    len_next = len_shift;
                    ovf_next = ovf_shift;
                    cnt_next = cnt_inc;
                    if (cnt_inc == (long_reg ? wsfd_pkg::EXT64_BYTES
                                             : wsfd_pkg::EXT16_BYTES))
                    begin
                        // length complete: saturate and move on
                        len_next  = len_final;
                        cnt_next  = '0;
                        kidx_next = '0;
                        if (masked_reg)
                            phase_next = wsfd_pkg::PH_KEY;
                        else if (len_final == '0)
                            phase_next = wsfd_pkg::PH_HDR0;
                        else
                            phase_next = wsfd_pkg::PH_DATA;
                    end
                end
                wsfd_pkg::PH_KEY:
                begin
                    key_next = {key_reg[23:0], in_byte};
                    cnt_next = cnt_inc;
                    if (cnt_inc == wsfd_pkg::KEY_BYTES)
                    begin
                        cnt_next   = '0;
                        kidx_next  = '0;
                        phase_next = (len_reg == '0) ? wsfd_pkg::PH_HDR0
                                                     : wsfd_pkg::PH_DATA;
                    end
                end
                wsfd_pkg::PH_DATA:
                begin
                    res.valid = (opcode_reg == wsfd_pkg::OPC_TEXT);
                    res.data  = in_byte ^ key_byte;
                    res.last  = (len_reg == {{(LENGTH_BITS-1){1'b0}}, 1'b1});
                    res.fin   = fin_reg;
                    len_next  = len_reg - {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                    kidx_next = kidx_reg + 2'd1;
                    if (res.last)
                        phase_next = wsfd_pkg::PH_HDR0;
                end
                default:
                begin
                    // first header byte; reserved bits ignored
                    fin_next    = in_byte[wsfd_pkg::FIN_BIT];
                    opcode_next = in_byte[3:0];
                    phase_next  = wsfd_pkg::PH_HDR1;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= wsfd_pkg::PH_HDR0;
            cnt_reg    <= '0;
            long_reg   <= 1'b0;
            opcode_reg <= '0;
            fin_reg    <= 1'b0;
            masked_reg <= 1'b0;
            len_reg    <= '0;
            ovf_reg    <= 1'b0;
            key_reg    <= '0;
            kidx_reg   <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            cnt_reg    <= cnt_next;
            long_reg   <= long_next;
            opcode_reg <= opcode_next;
            fin_reg    <= fin_next;
            masked_reg <= masked_next;
            len_reg    <= len_next;
            ovf_reg    <= ovf_next;
            key_reg    <= key_next;
            kidx_reg   <= kidx_next;
        end
    end

endmodule
